// ===== rtl/apu_rt_pkg.sv =====
// Shared types, constants and lookup functions for the register translator.
package apu_rt_pkg;

  localparam int SHADOW_DEPTH = 32;
  localparam int ORDER_LEN    = 18;
  localparam int SEQ_W        = 5;
  localparam logic [22:0] TRI_NUM = 23'd4222604;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_INVAL = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       src_write;   // apply source write
    logic       div_start;   // load divider
    logic       div_step;    // one restoring step
    logic       div_done;    // store triangle rate
    logic       img_build;   // latch target image
    logic       walk_step;   // examine one order entry
    logic       clock_units; // run frame units once
    logic       invalidate;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic       tri_write;   // current write touches the triangle timer
    logic       emit_hit;    // current walk entry must be emitted
    logic       walk_end;    // walk index is on the last entry
  } dp_stat_t;

  function automatic logic [7:0] len_lut(input logic [4:0] i);
    logic [7:0] v;
    case (i)
      5'd0: v = 8'd10;   5'd1: v = 8'd254;  5'd2: v = 8'd20;  5'd3: v = 8'd2;
      5'd4: v = 8'd40;   5'd5: v = 8'd4;    5'd6: v = 8'd80;  5'd7: v = 8'd6;
      5'd8: v = 8'd160;  5'd9: v = 8'd8;    5'd10: v = 8'd60; 5'd11: v = 8'd10;
      5'd12: v = 8'd14;  5'd13: v = 8'd12;  5'd14: v = 8'd26; 5'd15: v = 8'd14;
      5'd16: v = 8'd12;  5'd17: v = 8'd16;  5'd18: v = 8'd24; 5'd19: v = 8'd18;
      5'd20: v = 8'd48;  5'd21: v = 8'd20;  5'd22: v = 8'd96; 5'd23: v = 8'd22;
      5'd24: v = 8'd192; 5'd25: v = 8'd24;  5'd26: v = 8'd72; 5'd27: v = 8'd26;
      5'd28: v = 8'd16;  5'd29: v = 8'd28;  5'd30: v = 8'd32; 5'd31: v = 8'd30;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] noise_lut(input logic [3:0] i);
    logic [7:0] v;
    case (i)
      4'd0, 4'd1, 4'd2: v = 8'd1;
      4'd3: v = 8'd2;  4'd4: v = 8'd4;  4'd5: v = 8'd7;  4'd6: v = 8'd9;
      4'd7: v = 8'd11; 4'd8: v = 8'd14; 4'd9: v = 8'd18; 4'd10: v = 8'd27;
      default: v = 8'd31;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] emit_seq(input logic [SEQ_W-1:0] k);
    logic [4:0] v;
    case (k)
      5'd0: v = 5'h01;  5'd1: v = 5'h00;  5'd2: v = 5'h03;  5'd3: v = 5'h02;
      5'd4: v = 5'h06;  5'd5: v = 5'h07;  5'd6: v = 5'h08;  5'd7: v = 5'h09;
      5'd8: v = 5'h0a;  5'd9: v = 5'h11;  5'd10: v = 5'h12; 5'd11: v = 5'h13;
      5'd12: v = 5'h14; 5'd13: v = 5'h15; 5'd14: v = 5'h19; 5'd15: v = 5'h1a;
      5'd16: v = 5'h1b; 5'd17: v = 5'h10;
      default: v = 5'h00;
    endcase
    return v;
  endfunction

  // ((t+1)*286 + 128) >> 8, clamped to 1..4095
  function automatic logic [11:0] tone_period(input logic [10:0] t);
    logic [20:0] s;
    s = ({10'd0, t} + 21'd1) * 21'd286 + 21'd128;
    if (s[20:8] == 13'd0) return 12'd1;
    if (s[20] != 1'b0) return 12'hfff;
    return s[19:8];
  endfunction

endpackage

// ===== rtl/apu_rt_ctrl.sv =====
// Controller state machine: sequences writes, division, frame walk and unit clocking.
module apu_rt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_func,
  input  logic                in_emit_enable,
  output logic                out_valid,
  input  logic                out_ready,
  output apu_rt_pkg::dp_cmd_t cmd,
  input  apu_rt_pkg::dp_stat_t stat
);
  import apu_rt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_BUILD = 7'b0000100,
    S_WALK  = 7'b0001000,
    S_EMIT  = 7'b0010000,
    S_CLK   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (func_t'(in_func))
            FUNC_WRITE: begin
              cmd.src_write = 1'b1;
              if (stat.tri_write) begin
                cmd.div_start = 1'b1;
                cnt_nxt       = 5'd0;
                state_nxt     = S_DIV;
              end
            end
            FUNC_TICK: begin
              if (in_emit_enable) state_nxt = S_BUILD;
              else state_nxt = S_CLK;
            end
            FUNC_INVAL: cmd.invalidate = 1'b1;
            default: ;
          endcase
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'd22) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.div_done = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_BUILD: begin
        cmd.img_build = 1'b1;
        state_nxt     = S_WALK;
      end
      S_WALK: begin
        if (stat.emit_hit) state_nxt = S_EMIT;
        else begin
          cmd.walk_step = 1'b1;
          if (stat.walk_end) state_nxt = S_CLK;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          cmd.walk_step = 1'b1;
          state_nxt     = stat.walk_end ? S_CLK : S_WALK;
        end
      end
      S_CLK: begin
        cmd.clock_units = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/apu_rt_dp.sv =====
// Datapath: source state, frame units, rate divider, image, shadow and walk.
module apu_rt_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [15:0]          in_apu_address,
  input  logic [7:0]           in_apu_data,
  input  apu_rt_pkg::dp_cmd_t  cmd,
  output apu_rt_pkg::dp_stat_t stat,
  output logic [4:0]           out_target_register,
  output logic [7:0]           out_target_data,
  output logic                 out_last
);
  import apu_rt_pkg::*;

  logic [7:0]  pctl_r [2];
  logic [7:0]  psw_r  [2];
  logic [10:0] pper_r [2];
  logic [7:0]  plen_r [2];
  logic [2:0]  sdiv_r [2];
  logic        srel_r [2];
  logic        smute_r[2];
  logic [3:0]  edec_r [3];
  logic [3:0]  ediv_r [3];
  logic [7:0]  tctl_r, tlen_r, nctl_r, nlen_r;
  logic [10:0] tper_r;
  logic [6:0]  tlin_r;
  logic        trel_r;
  logic [15:0] trate_r;
  logic [3:0]  nsel_r, en_r;
  logic [SHADOW_DEPTH-1:0] sval_r;
  logic [7:0]  shadow_mem [SHADOW_DEPTH];
  logic [7:0]  img_r [ORDER_LEN];
  logic [SEQ_W-1:0] k_r;
  logic [7:0]  sh_rd_r;

  // divider
  logic [22:0] quo_r;
  logic [11:0] den_r;
  logic [12:0] rem_r;
  logic        short_r;

  logic [15:0] addr;
  logic [7:0]  v;
  logic        ch;
  assign addr = in_apu_address;
  assign v    = in_apu_data;
  assign ch   = addr[2];

  assign stat.tri_write = (addr == 16'h400a) || (addr == 16'h400b);

  // Sweep target / mute on a given ctrl and period
  function automatic logic mute_of(input logic [7:0] c, input logic [10:0] t);
    logic [11:0] sum;
    sum = {1'b0, t} + {1'b0, t >> c[2:0]};
    return (t < 11'd8) || (!c[3] && sum[11]);
  endfunction

  function automatic logic [10:0] tgt_of(input logic [7:0] c, input logic [10:0] t,
                                         input logic c0);
    logic [11:0] sub;
    logic [11:0] sum;
    sub = {1'b0, t >> c[2:0]} + {11'd0, c0};
    sum = {1'b0, t} + {1'b0, t >> c[2:0]};
    if (c[3]) return (sub > {1'b0, t}) ? 11'd0 : t - sub[10:0];
    return sum[10:0];
  endfunction

  // image build
  logic [7:0] img [ORDER_LEN];
  always_comb begin
    logic [11:0] p0, p1;
    logic [3:0]  v0, v1, nv;
    logic [7:0]  mix;
    logic        lin;
    p0 = tone_period(pper_r[0]);
    p1 = tone_period(pper_r[1]);
    mix = 8'h3f;
    v0 = pctl_r[0][4] ? pctl_r[0][3:0] : edec_r[0];
    v1 = pctl_r[1][4] ? pctl_r[1][3:0] : edec_r[1];
    nv = nctl_r[4] ? nctl_r[3:0] : edec_r[2];
    if (en_r[0] && plen_r[0] != 0 && pper_r[0] >= 11'd8 && !smute_r[0] && v0 != 0)
      mix[0] = 1'b0;
    else v0 = 4'd0;
    if (en_r[1] && plen_r[1] != 0 && pper_r[1] >= 11'd8 && !smute_r[1] && v1 != 0)
      mix[1] = 1'b0;
    else v1 = 4'd0;
    if (en_r[3] && nlen_r != 0 && nv != 0) mix[5] = 1'b0;
    else nv = 4'd0;
    lin = (tlin_r != 0) || (trel_r && tctl_r[6:0] != 0);
    img[0]  = {4'd0, p0[11:8]};
    img[1]  = p0[7:0];
    img[2]  = {4'd0, p1[11:8]};
    img[3]  = p1[7:0];
    img[4]  = noise_lut(nsel_r);
    img[5]  = mix;
    img[6]  = {4'd0, v0};
    img[7]  = {4'd0, v1};
    img[8]  = {4'd0, nv};
    img[9]  = 8'hc0;
    img[10] = 8'h00;
    img[11] = 8'h00;
    img[12] = 8'hff;
    img[13] = 8'h00;
    img[14] = trate_r[7:0];
    img[15] = trate_r[15:8];
    img[16] = 8'h70;
    img[17] = (en_r[2] && tlen_r != 0 && lin && tper_r > 11'd2) ? 8'h90 : 8'h01;
  end

  logic [4:0] reg_k;
  logic [7:0] dat_k;
  assign reg_k = emit_seq(k_r);
  assign dat_k = img_r[k_r];
  assign stat.emit_hit = !(sval_r[reg_k] && sh_rd_r == dat_k);
  assign stat.walk_end = (k_r == SEQ_W'(ORDER_LEN - 1));

  // last: no later entry will need emitting
  logic later_hit;
  always_comb begin
    later_hit = 1'b0;
    for (int j = 0; j < ORDER_LEN; j++) begin
      if (SEQ_W'(j) > k_r &&
          !(sval_r[emit_seq(SEQ_W'(j))] && shadow_mem[emit_seq(SEQ_W'(j))] == img_r[j]))
        later_hit = 1'b1;
    end
  end

  assign out_target_register = reg_k;
  assign out_target_data     = dat_k;
  assign out_last            = !later_hit;

  logic [12:0] trial;
  assign trial = {rem_r[11:0], quo_r[22]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.img_build) for (int j = 0; j < ORDER_LEN; j++) img_r[j] <= img[j];
    if (cmd.walk_step && stat.emit_hit) shadow_mem[reg_k] <= dat_k;
    sh_rd_r <= shadow_mem[cmd.walk_step ? emit_seq(k_r + SEQ_W'(1)) : reg_k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        pctl_r[i] <= '0; psw_r[i] <= '0; pper_r[i] <= '0; plen_r[i] <= '0;
        sdiv_r[i] <= '0; srel_r[i] <= 1'b0; smute_r[i] <= 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
        edec_r[i] <= '0; ediv_r[i] <= '0;
      end
      tctl_r <= '0; tlen_r <= '0; tlin_r <= '0; trel_r <= 1'b0; tper_r <= '0;
      trate_r <= 16'hffff;
      nctl_r <= '0; nsel_r <= '0; nlen_r <= '0; en_r <= '0;
      sval_r <= '0; k_r <= '0;
      quo_r <= '0; den_r <= '0; rem_r <= '0; short_r <= 1'b0;
    end else begin
      if (cmd.src_write) begin
        case (addr)
          16'h4000, 16'h4004: pctl_r[ch] <= v;
          16'h4001, 16'h4005: begin
            psw_r[ch] <= v; srel_r[ch] <= 1'b1;
            smute_r[ch] <= mute_of(v, pper_r[ch]);
          end
          16'h4002, 16'h4006: begin
            pper_r[ch] <= {pper_r[ch][10:8], v};
            smute_r[ch] <= mute_of(psw_r[ch], {pper_r[ch][10:8], v});
          end
          16'h4003, 16'h4007: begin
            pper_r[ch] <= {v[2:0], pper_r[ch][7:0]};
            if (en_r[ch]) plen_r[ch] <= len_lut(v[7:3]);
            edec_r[ch] <= 4'hf; ediv_r[ch] <= pctl_r[ch][3:0];
            smute_r[ch] <= mute_of(psw_r[ch], {v[2:0], pper_r[ch][7:0]});
          end
          16'h4008: tctl_r <= v;
          16'h400a: tper_r <= {tper_r[10:8], v};
          16'h400b: begin
            tper_r <= {v[2:0], tper_r[7:0]};
            if (en_r[2]) tlen_r <= len_lut(v[7:3]);
            trel_r <= 1'b1;
          end
          16'h400c: nctl_r <= v;
          16'h400e: nsel_r <= v[3:0];
          16'h400f: begin
            if (en_r[3]) nlen_r <= len_lut(v[7:3]);
            edec_r[2] <= 4'hf; ediv_r[2] <= nctl_r[3:0];
          end
          16'h4015: begin
            if (!v[0]) plen_r[0] <= '0;
            if (!v[1]) plen_r[1] <= '0;
            if (!v[2]) tlen_r <= '0;
            if (!v[3]) nlen_r <= '0;
            en_r <= v[3:0];
          end
          default: ;
        endcase
      end
      if (cmd.div_start) begin
        // tper_r not yet updated; recompute from the incoming byte
        logic [11:0] d;
        d = 12'(addr[0] ? {v[2:0], tper_r[7:0]} : {tper_r[10:8], v}) + 12'd1;
        den_r   <= d;
        short_r <= d < 12'd65;
        quo_r   <= TRI_NUM + 23'(d[11:1]);
        rem_r   <= '0;
      end
      if (cmd.div_step) begin
        if (!trial[12]) begin
          rem_r <= trial;
          quo_r <= {quo_r[21:0], 1'b1};
        end else begin
          rem_r <= {rem_r[11:0], quo_r[22]};
          quo_r <= {quo_r[21:0], 1'b0};
        end
      end
      if (cmd.div_done)
        trate_r <= (short_r || quo_r[22:16] != 0) ? 16'hffff : quo_r[15:0];
      if (cmd.invalidate) sval_r <= '0;
      if (cmd.img_build) k_r <= '0;
      if (cmd.walk_step) begin
        if (stat.emit_hit) sval_r[reg_k] <= 1'b1;
        k_r <= stat.walk_end ? '0 : k_r + SEQ_W'(1);
      end
      if (cmd.clock_units) begin : units
        logic [3:0] dc, dv;
        logic [7:0] c;
        logic [6:0] ln;
        logic       rl;
        logic [10:0] pp, tg;
        logic [2:0] sd;
        logic       sr, sm, wz;
        for (int i = 0; i < 3; i++) begin
          c  = (i == 2) ? nctl_r : pctl_r[i];
          dc = edec_r[i]; dv = ediv_r[i];
          if (!c[4]) begin
            for (int n = 0; n < 4; n++) begin
              if (dv != 0) dv = dv - 4'd1;
              else begin
                dv = c[3:0];
                if (dc != 0) dc = dc - 4'd1;
                else if (c[5]) dc = 4'hf;
              end
            end
          end
          edec_r[i] <= dc; ediv_r[i] <= dv;
        end
        ln = tlin_r; rl = trel_r;
        for (int n = 0; n < 4; n++) begin
          if (rl) ln = tctl_r[6:0];
          else if (ln != 0) ln = ln - 7'd1;
          if (!tctl_r[7]) rl = 1'b0;
        end
        tlin_r <= ln; trel_r <= rl;
        for (int i = 0; i < 2; i++)
          if (!pctl_r[i][5]) plen_r[i] <= (plen_r[i] > 8'd2) ? plen_r[i] - 8'd2 : 8'd0;
        if (!tctl_r[7]) tlen_r <= (tlen_r > 8'd2) ? tlen_r - 8'd2 : 8'd0;
        if (!nctl_r[5]) nlen_r <= (nlen_r > 8'd2) ? nlen_r - 8'd2 : 8'd0;
        for (int i = 0; i < 2; i++) begin
          c = psw_r[i]; pp = pper_r[i]; sd = sdiv_r[i]; sr = srel_r[i];
          for (int n = 0; n < 2; n++) begin
            wz = (sd == 0);
            tg = tgt_of(c, pp, i == 0);
            sm = mute_of(c, pp);
            if (wz && c[7] && c[2:0] != 0 && !sm) begin
              pp = tg;
              sm = mute_of(c, pp);
            end
            if (wz || sr) begin sd = c[6:4]; sr = 1'b0; end
            else sd = sd - 3'd1;
          end
          pper_r[i] <= pp; sdiv_r[i] <= sd; srel_r[i] <= sr; smute_r[i] <= sm;
        end
      end
    end
  end

endmodule

// ===== rtl/apu_register_translator_unit.sv =====
// Top level of the sound register translator.
// Usage:
//  - in_* channel (valid/ready) takes one item: source write, frame tick or
//    shadow invalidate. in_ready is high only while the block is idle.
//  - out_* channel (valid/ready) delivers target chip writes, up to 18 per
//    frame tick, out_last marking the final one of that tick.
//  - A write is applied from the idle state; a triangle timer write also runs
//    a restoring divider, one quotient bit per cycle, then stores the rate.
//  - A frame tick with in_emit_enable high latches the image, then walks the
//    order entries (18), entering S_EMIT for each write to emit, then clocks
//    the envelope, linear, length and sweep units; with in_emit_enable low
//    it only clocks the units.
//  - If the receiver stalls, the pending write holds on the out_* ports and
//    the walk waits; nothing is dropped.
//  - Reset (rst_n low, synchronous) clears all voice state, sets both
//    sweep mute flags and the triangle rate to all ones and marks every
//    shadow entry invalid; shadow data needs no clearing.
module apu_register_translator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_apu_address,
  input  logic [7:0]  in_apu_data,
  input  logic        in_emit_enable,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_target_register,
  output logic [7:0]  out_target_data,
  output logic        out_last
);
  import apu_rt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  apu_rt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_emit_enable,
    .out_valid, .out_ready, .cmd, .stat
  );

  apu_rt_dp u_dp (
    .clk, .rst_n, .in_apu_address, .in_apu_data, .cmd, .stat,
    .out_target_register, .out_target_data, .out_last
  );

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output active together");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_target_data))
    else $error("pending write changed");
  a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.src_write, cmd.div_step, cmd.img_build, cmd.clock_units}))
    else $error("conflicting commands");

endmodule
